FILE: rtl/imu_fp_pkg.sv
`default_nettype none

package imu_fp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned AXIS_W      = 25;
    localparam int unsigned STORE_DEPTH = 7;
    localparam int unsigned STORE_AW    = 3;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL  = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_RATE   = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE  = 8'h53;

    // exact q13 factors: 16/32768*8192 = 4, 2000/32768*8192 = 500, 180/32768*8192 = 45
    localparam logic signed [AXIS_W-1:0] SCALE_ACCEL = 25'sd4;
    localparam logic signed [AXIS_W-1:0] SCALE_RATE  = 25'sd500;
    localparam logic signed [AXIS_W-1:0] SCALE_ANGLE = 25'sd45;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [AXIS_W-1:0]   t_axis;

endpackage

`default_nettype wire

FILE: rtl/imu_fp_scale.sv
`default_nettype none

module imu_fp_scale
    import imu_fp_pkg::*;
(
    input  wire t_kind   i_kind,
    input  wire t_sample i_raw,
    output t_axis        o_value
);

    t_axis w_ext;

    assign w_ext = AXIS_W'(i_raw);

    always_comb begin
        unique case (i_kind)
            KIND_ACCEL: o_value = w_ext * SCALE_ACCEL;
            KIND_RATE:  o_value = w_ext * SCALE_RATE;
            KIND_ANGLE: o_value = w_ext * SCALE_ANGLE;
            default:    o_value = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/imu_frame_parser.sv
// the beat carrying the last frame byte loads the sample register; the result then moves on to the output register
// throughput: one byte beat per cycle while o_stall is low, also while a result waits
// a result is held in an output register; a second finished frame waits in the
// sample register, and only then is the input stalled
// reset (synchronous, active low) clears the byte counter and both valid flags
`default_nettype none

module imu_frame_parser
    import imu_fp_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 11
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire [BYTE_W-1:0]         i_rx_byte,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [1:0]               o_kind,
    output logic signed [AXIS_W-1:0] o_axis_x,
    output logic signed [AXIS_W-1:0] o_axis_y,
    output logic signed [AXIS_W-1:0] o_axis_z
);

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [BYTE_W-1:0] r_store [STORE_DEPTH];
    logic [BYTE_W-1:0] n_store [STORE_DEPTH];

    logic    r_p_valid;
    t_kind   r_p_kind;
    t_sample r_p_raw [3];

    logic  r_o_valid;
    t_kind r_o_kind;
    t_axis r_o_axis [3];
    t_axis w_scaled [3];

    logic  w_accept;
    logic  w_advance;
    logic  w_last;
    logic  w_known;
    logic  w_load;
    t_kind w_kind;

    assign w_advance = !r_o_valid || !i_stall;
    assign o_stall   = r_p_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;
    assign w_last    = r_count >= CNT_W'(FRAME_BYTES - 1);

    // store update with the current byte merged in, so a short frame sees its own last byte
    always_comb begin
        n_store = r_store;
        if (r_count != '0 && r_count <= CNT_W'(STORE_DEPTH)) begin
            n_store[STORE_AW'(r_count - CNT_W'(1))] = i_rx_byte;
        end
    end

    always_comb begin
        w_known = 1'b1;
        unique case (n_store[0])
            TYPE_ACCEL: w_kind = KIND_ACCEL;
            TYPE_RATE:  w_kind = KIND_RATE;
            TYPE_ANGLE: w_kind = KIND_ANGLE;
            default: begin
                w_kind  = KIND_ACCEL;
                w_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (r_count == '0) begin
            if (i_rx_byte == HEADER_BYTE) begin
                n_count = CNT_W'(1);
            end
        end else if (w_last) begin
            n_count = '0;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
    end

    assign w_load = w_accept && r_count != '0 && w_last && w_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_p_valid <= 1'b1;
            end else if (w_advance) begin
                r_p_valid <= 1'b0;
            end
            if (w_advance) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store <= n_store;
        end
        if (w_load) begin
            r_p_kind   <= w_kind;
            r_p_raw[0] <= {n_store[2], n_store[1]};
            r_p_raw[1] <= {n_store[4], n_store[3]};
            r_p_raw[2] <= {n_store[6], n_store[5]};
        end
        if (w_advance && r_p_valid) begin
            r_o_kind <= r_p_kind;
            r_o_axis <= w_scaled;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        imu_fp_scale u_scale (
            .i_kind  (r_p_kind),
            .i_raw   (r_p_raw[g]),
            .o_value (w_scaled[g])
        );
    end

    assign o_valid  = r_o_valid;
    assign o_kind   = r_o_kind;
    assign o_axis_x = r_o_axis[0];
    assign o_axis_y = r_o_axis[1];
    assign o_axis_z = r_o_axis[2];

    // counter never passes the last frame position
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < (CNT_W + 1)'(FRAME_BYTES))
        else $error("byte counter out of range");

    // a stray byte while hunting for the header leaves the counter at zero
    a_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_count == '0 && i_rx_byte != HEADER_BYTE) |=> r_count == '0)
        else $error("counter left zero without a header");

    // a finished frame always returns the counter to zero
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_count != '0 && w_last) |=> r_count == '0)
        else $error("counter not cleared at frame end");

    // a frame only enters the sample register when the input is not stalled
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_p_valid || w_advance))
        else $error("sample register overwritten");

endmodule

`default_nettype wire
